>>> design/kvbt_pkg.sv
// shared types, constants and codes for the block table with clock-sweep eviction
`timescale 1ns / 1ps
`default_nettype none
package kvbt_pkg;

   localparam int NUM_SLOTS   = 1024;
   localparam int NUM_LOGICAL = 4096;
   localparam int MAX_POP     = 64;

   localparam int SLOT_W  = $clog2(NUM_SLOTS);
   localparam int LB_W    = $clog2(NUM_LOGICAL);
   localparam int CNT_W   = SLOT_W + 1;
   localparam int PIN_W   = 16;
   localparam int USE_W   = 7;
   localparam int Q_W     = 7;
   localparam int CMP_W   = (CNT_W > Q_W) ? CNT_W : Q_W;
   localparam int MAP_W   = SLOT_W + 1;
   localparam int CLR_W   = (LB_W > SLOT_W) ? LB_W : SLOT_W;

   localparam logic [1:0]       COND_RESIDENT = 2'd3;
   localparam logic [USE_W-1:0] USE_MAX       = {USE_W{1'b1}};
   localparam logic [PIN_W-1:0] PIN_MAX       = {PIN_W{1'b1}};

   // action codes
   localparam logic [3:0] ACT_LOAD     = 4'd0;
   localparam logic [3:0] ACT_SAVE     = 4'd1;
   localparam logic [3:0] ACT_BLOCK    = 4'd2;
   localparam logic [3:0] ACT_POP      = 4'd3;
   localparam logic [3:0] ACT_EVICT    = 4'd4;
   localparam logic [3:0] ACT_MAP_MISS = 4'd5;
   localparam logic [3:0] ACT_SET_PINS = 4'd6;
   localparam logic [3:0] ACT_TOUCH    = 4'd7;
   localparam logic [3:0] ACT_COMMIT   = 4'd8;
   localparam logic [3:0] ACT_SET_COND = 4'd9;

   // status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_BUSY   = 2'd1;
   localparam logic [1:0] ST_NOPOOL = 2'd2;

   // one slot memory word; ok is pop scratch
   typedef struct packed {
      logic             ok;
      logic             blocked;
      logic             free;
      logic [1:0]       cond;
      logic [PIN_W-1:0] pins;
      logic [USE_W-1:0] use_cnt;
   } slot_entry_type;

   localparam int SLOT_ENTRY_W = $bits(slot_entry_type);

   typedef struct packed {
      logic              valid;
      logic [SLOT_W-1:0] slot;
   } map_entry_type;

   typedef struct packed {
      logic [SLOT_W-1:0] out_slot;
      logic              is_hit;
      logic [PIN_W-1:0]  out_pins;
      logic [USE_W-1:0]  out_use;
      logic [1:0]        status;
      logic              last;
   } result_type;

endpackage
`default_nettype wire

>>> design/kv_block_table_eviction_top.sv
// block table top level: lookups, commit steps and clock-sweep pop over slot memory
// lookups go through map read, slot read (on a map hit) and result register; writes go
// through the map and, except for evict, a slot read-modify-write. one item is worked at a
// time; a pop sweeps the slot memory once to snapshot and clear block marks, then, if the
// quantity is nonzero and enough slots qualify, 7 counting sweeps find the threshold, a
// select walk checks slots in turn and, if the threshold is nonzero, an aging sweep runs.
// after reset a clearing pass zeroes map and slot memory; no item is accepted during it.
`timescale 1ns / 1ps
`default_nettype none
module kv_block_table_eviction_top
   import kvbt_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic [3:0]        req_action,
   input  wire logic [11:0]       req_logical_block,
   input  wire logic [9:0]        req_slot,
   input  wire logic [6:0]        req_pop_quantity,
   input  wire logic [15:0]       req_pin_value,
   input  wire logic [6:0]        req_use_value,
   input  wire logic [1:0]        req_condition_code,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic [9:0]             rsp_out_slot,
   output logic                   rsp_is_hit,
   output logic [15:0]            rsp_out_pins,
   output logic [6:0]             rsp_out_use,
   output logic [1:0]             rsp_status,
   output logic                   rsp_last
);

   typedef enum logic [9:0] {
      S_CLEAR   = 10'b0000000001,
      S_IDLE    = 10'b0000000010,
      S_MAP     = 10'b0000000100,
      S_SLOT    = 10'b0000001000,
      S_EMIT    = 10'b0000010000,
      S_P0      = 10'b0000100000,
      S_CNT     = 10'b0001000000,
      S_SEL_RD  = 10'b0010000000,
      S_SEL_CHK = 10'b0100000000,
      S_AGE     = 10'b1000000000
   } state_type;

   state_type          state_ff, state_in;
   logic [3:0]         act_ff, act_in;
   logic [SLOT_W-1:0]  slot_ff, slot_in;
   logic [Q_W-1:0]     q_ff, q_in;
   logic [PIN_W-1:0]   pv_ff, pv_in;
   logic [USE_W-1:0]   uv_ff, uv_in;
   logic [1:0]         cc_ff, cc_in;
   logic [CNT_W-1:0]   iss_ff, iss_in;
   logic               vld_ff, vld_in;
   logic [SLOT_W-1:0]  wa_ff, wa_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [USE_W-1:0]   lo_ff, lo_in;
   logic [USE_W-1:0]   hi_ff, hi_in;
   logic [SLOT_W-1:0]  pos_ff, pos_in;
   logic [Q_W-1:0]     taken_ff, taken_in;
   logic [SLOT_W-1:0]  scan_ff, scan_in;
   logic [CLR_W-1:0]   clr_ff, clr_in;
   result_type         res_ff, res_in;
   result_type         rsp_ff;
   logic               rsp_valid_ff;

   logic               map_we, map_re;
   logic [LB_W-1:0]    map_wa, map_ra;
   map_entry_type      map_wd, map_rd;
   logic               slot_we, slot_re;
   logic [SLOT_W-1:0]  slot_wa, slot_ra;
   slot_entry_type     slot_wd, slot_rd;

   logic               out_free, load_out;
   result_type         out_res;
   logic               accept, issuing, pass_end, sel_match;
   logic [USE_W-1:0]   mid, nlo, nhi;
   logic [SLOT_W-1:0]  pos_next;
   logic [CMP_W-1:0]   cnt_x, q_x;

   kvbt_ram #(.WIDTH(MAP_W), .DEPTH(NUM_LOGICAL)) u_map_ram (
      .clock (clock),
      .we    (map_we),
      .waddr (map_wa),
      .wdata (map_wd),
      .re    (map_re),
      .raddr (map_ra),
      .rdata (map_rd)
   );

   kvbt_ram #(.WIDTH(SLOT_ENTRY_W), .DEPTH(NUM_SLOTS)) u_slot_ram (
      .clock (clock),
      .we    (slot_we),
      .waddr (slot_wa),
      .wdata (slot_wd),
      .re    (slot_re),
      .raddr (slot_ra),
      .rdata (slot_rd)
   );

   // handshake helpers
   assign req_stall = (state_ff != S_IDLE);
   assign accept    = req_valid && (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign issuing   = (iss_ff < CNT_W'(NUM_SLOTS));
   assign pass_end  = !issuing && !vld_ff;
   assign mid       = USE_W'((({1'b0, lo_ff}) + ({1'b0, hi_ff})) >> 1);
   assign cnt_x     = CMP_W'(cnt_ff);
   assign q_x       = CMP_W'(q_ff);
   assign pos_next  = (pos_ff == SLOT_W'(NUM_SLOTS - 1)) ? '0 : pos_ff + 1'b1;
   assign sel_match = slot_rd.ok && (slot_rd.use_cnt <= lo_ff);

   // binary search step on the usage threshold
   always_comb begin
      nlo = lo_ff;
      nhi = hi_ff;
      if (cnt_x >= q_x) begin
         nhi = mid;
      end else begin
         nlo = mid + 1'b1;
      end
   end

   // main sequencer
   always_comb begin
      state_in = state_ff;
      act_in   = act_ff;
      slot_in  = slot_ff;
      q_in     = q_ff;
      pv_in    = pv_ff;
      uv_in    = uv_ff;
      cc_in    = cc_ff;
      iss_in   = iss_ff;
      vld_in   = 1'b0;
      wa_in    = wa_ff;
      cnt_in   = cnt_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      pos_in   = pos_ff;
      taken_in = taken_ff;
      scan_in  = scan_ff;
      clr_in   = clr_ff;
      res_in   = res_ff;
      map_we   = 1'b0;
      map_wa   = req_logical_block;
      map_wd   = '0;
      map_re   = 1'b0;
      map_ra   = req_logical_block;
      slot_we  = 1'b0;
      slot_wa  = slot_ff;
      slot_wd  = slot_rd;
      slot_re  = 1'b0;
      slot_ra  = slot_ff;
      load_out = 1'b0;
      out_res  = res_ff;

      unique case (state_ff)
         // zero both memories after reset
         S_CLEAR: begin
            map_we = 1'b1;
            map_wa = LB_W'(clr_ff);
            map_wd = '0;
            if ({1'b0, clr_ff} < (CLR_W + 1)'(NUM_SLOTS)) begin
               slot_we = 1'b1;
               slot_wa = SLOT_W'(clr_ff);
               slot_wd = '0;
            end
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLR_W'(NUM_LOGICAL - 1)) begin
               state_in = S_IDLE;
            end
         end

         // take an item, read the map and do direct map writes
         S_IDLE: begin
            if (accept) begin
               act_in  = req_action;
               slot_in = req_slot;
               q_in    = req_pop_quantity;
               pv_in   = req_pin_value;
               uv_in   = req_use_value;
               cc_in   = req_condition_code;
               if (req_action == ACT_POP) begin
                  iss_in   = '0;
                  cnt_in   = '0;
                  state_in = S_P0;
               end else begin
                  map_re = 1'b1;
                  if (req_action == ACT_EVICT) begin
                     map_we = 1'b1;
                  end else if (req_action == ACT_MAP_MISS || req_action == ACT_COMMIT) begin
                     map_we = 1'b1;
                     map_wd = '{valid: 1'b1, slot: req_slot};
                  end
                  state_in = S_MAP;
               end
            end
         end

         // map data back: resolve lookups, start slot read-modify-write
         S_MAP: begin
            if (act_ff == ACT_LOAD || act_ff == ACT_SAVE) begin
               if (!map_rd.valid) begin
                  res_in = '{out_slot: '0, is_hit: 1'b0, out_pins: '0,
                             out_use: USE_W'(act_ff == ACT_SAVE), status: ST_OK,
                             last: 1'b1};
                  state_in = S_EMIT;
               end else begin
                  slot_re  = 1'b1;
                  slot_ra  = map_rd.slot;
                  slot_in  = map_rd.slot;
                  state_in = S_SLOT;
               end
            end else if (act_ff == ACT_BLOCK || act_ff == ACT_MAP_MISS ||
                         act_ff == ACT_SET_PINS || act_ff == ACT_TOUCH ||
                         act_ff == ACT_COMMIT || act_ff == ACT_SET_COND) begin
               slot_re  = 1'b1;
               state_in = S_SLOT;
            end else begin
               state_in = S_IDLE;
            end
         end

         // slot data back: lookup result or write back
         S_SLOT: begin
            if (act_ff == ACT_LOAD || act_ff == ACT_SAVE) begin
               if (slot_rd.cond != COND_RESIDENT) begin
                  res_in = '{out_slot: slot_ff, is_hit: 1'b1, out_pins: '0,
                             out_use: '0, status: ST_BUSY, last: 1'b1};
               end else begin
                  res_in.out_slot = slot_ff;
                  res_in.is_hit   = 1'b1;
                  res_in.out_use  = (slot_rd.use_cnt == USE_MAX) ? USE_MAX
                                    : slot_rd.use_cnt + 1'b1;
                  res_in.out_pins = '0;
                  if (act_ff == ACT_LOAD) begin
                     res_in.out_pins = (slot_rd.pins == PIN_MAX) ? PIN_MAX
                                       : slot_rd.pins + 1'b1;
                  end
                  res_in.status = ST_OK;
                  res_in.last   = 1'b1;
               end
               state_in = S_EMIT;
            end else begin
               slot_we = 1'b1;
               if (act_ff == ACT_BLOCK) begin
                  slot_wd.blocked = 1'b1;
               end else if (act_ff == ACT_MAP_MISS) begin
                  slot_wd.cond = COND_RESIDENT;
                  slot_wd.pins = PIN_W'(1);
               end else if (act_ff == ACT_SET_PINS) begin
                  slot_wd.pins = pv_ff;
               end else if (act_ff == ACT_TOUCH) begin
                  slot_wd.free    = 1'b0;
                  slot_wd.use_cnt = uv_ff;
               end else if (act_ff == ACT_COMMIT) begin
                  slot_wd.cond    = COND_RESIDENT;
                  slot_wd.pins    = pv_ff;
                  slot_wd.use_cnt = uv_ff;
                  slot_wd.free    = (pv_ff == '0);
               end else begin
                  slot_wd.cond = cc_ff;
               end
               state_in = S_IDLE;
            end
         end

         // hand a single result to the output register
         S_EMIT: begin
            if (out_free) begin
               load_out = 1'b1;
               out_res  = res_ff;
               state_in = S_IDLE;
            end
         end

         // sweeps: snapshot/clear marks, count under threshold, age
         S_P0, S_CNT, S_AGE: begin
            if (issuing) begin
               slot_re = 1'b1;
               slot_ra = SLOT_W'(iss_ff);
               iss_in  = iss_ff + 1'b1;
               vld_in  = 1'b1;
               wa_in   = SLOT_W'(iss_ff);
            end
            slot_wa = wa_ff;
            if (vld_ff) begin
               if (state_ff == S_P0) begin
                  slot_we         = 1'b1;
                  slot_wd.ok      = slot_rd.free && !slot_rd.blocked;
                  slot_wd.blocked = 1'b0;
                  cnt_in = cnt_ff + CNT_W'(slot_rd.free && !slot_rd.blocked);
               end else if (state_ff == S_CNT) begin
                  cnt_in = cnt_ff + CNT_W'(slot_rd.ok && (slot_rd.use_cnt <= mid));
               end else begin
                  slot_we         = 1'b1;
                  slot_wd.use_cnt = (slot_rd.use_cnt > lo_ff) ? slot_rd.use_cnt - lo_ff
                                    : '0;
               end
            end
            if (pass_end) begin
               iss_in = '0;
               cnt_in = '0;
               if (state_ff == S_P0) begin
                  if (q_ff == '0) begin
                     state_in = S_IDLE;
                  end else if (q_x > CMP_W'(MAX_POP) || q_x > cnt_x) begin
                     res_in = '{out_slot: '0, is_hit: 1'b0, out_pins: '0,
                                out_use: '0, status: ST_NOPOOL, last: 1'b1};
                     state_in = S_EMIT;
                  end else begin
                     lo_in    = '0;
                     hi_in    = USE_MAX;
                     state_in = S_CNT;
                  end
               end else if (state_ff == S_CNT) begin
                  lo_in = nlo;
                  hi_in = nhi;
                  if (nlo == nhi) begin
                     pos_in   = scan_ff;
                     taken_in = '0;
                     state_in = S_SEL_RD;
                  end
               end else begin
                  state_in = S_IDLE;
               end
            end
         end

         // select walk: read one slot
         S_SEL_RD: begin
            slot_re  = 1'b1;
            slot_ra  = pos_ff;
            state_in = S_SEL_CHK;
         end

         // select walk: emit the slot if it qualifies
         S_SEL_CHK: begin
            if (sel_match) begin
               if (out_free) begin
                  load_out = 1'b1;
                  out_res  = '{out_slot: pos_ff, is_hit: 1'b0, out_pins: '0,
                               out_use: '0, status: ST_OK,
                               last: (Q_W'(taken_ff + 1'b1) == q_ff)};
                  taken_in = taken_ff + 1'b1;
                  pos_in   = pos_next;
                  if (Q_W'(taken_ff + 1'b1) == q_ff) begin
                     scan_in = pos_next;
                     iss_in  = '0;
                     state_in = (lo_ff != '0) ? S_AGE : S_IDLE;
                  end else begin
                     state_in = S_SEL_RD;
                  end
               end
            end else begin
               pos_in   = pos_next;
               state_in = S_SEL_RD;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
         scan_ff  <= '0;
         vld_ff   <= 1'b0;
         iss_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
         scan_ff  <= scan_in;
         vld_ff   <= vld_in;
         iss_ff   <= iss_in;
      end
   end

   // item and working registers
   always_ff @(posedge clock) begin
      act_ff   <= act_in;
      slot_ff  <= slot_in;
      q_ff     <= q_in;
      pv_ff    <= pv_in;
      uv_ff    <= uv_in;
      cc_ff    <= cc_in;
      wa_ff    <= wa_in;
      cnt_ff   <= cnt_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      pos_ff   <= pos_in;
      taken_ff <= taken_in;
      res_ff   <= res_in;
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         rsp_ff <= out_res;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_slot = rsp_ff.out_slot;
   assign rsp_is_hit   = rsp_ff.is_hit;
   assign rsp_out_pins = rsp_ff.out_pins;
   assign rsp_out_use  = rsp_ff.out_use;
   assign rsp_status   = rsp_ff.status;
   assign rsp_last     = rsp_ff.last;

   // checks
   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("accepted item did not start work");

   a_nopool_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_NOPOOL) |-> rsp_last)
      else $error("failed pop result not marked last");

   a_busy_no_pins: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_BUSY) |-> (rsp_out_pins == '0 && rsp_is_hit))
      else $error("busy result carries pins or no hit");

   a_no_load_when_full: assert property (@(posedge clock) disable iff (reset)
      load_out |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwritten while stalled");

endmodule
`default_nettype wire

>>> design/kvbt_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
`default_nettype none
module kvbt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   // write port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // read port, data holds while re is low
   always_ff @(posedge clock) begin
      if (re) begin
         rdata <= mem[raddr];
      end
   end

endmodule
`default_nettype wire
